// ----- rtl/core/pwm_prescaler_period_search_macros.svh -----
// Assertion macros for the PWM prescaler and period search core.
// Included by the modules that carry concurrent checks; expects clk and rst in scope.
`ifndef PWM_PRESCALER_PERIOD_SEARCH_MACROS_SVH
`define PWM_PRESCALER_PERIOD_SEARCH_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PPS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/pwmpps_pkg.sv -----
// Types, constants and microcode table for the PWM prescaler and period search.
// No dependencies; imported by pwm_prescaler_period_search.
package pwmpps_pkg;

  // Datapath widths
  localparam int BUS_W     = 28;
  localparam int CLK_W     = 30;   // bus clock times four
  localparam int FREQ_W    = 24;   // a frequency that passes the range test fits here
  localparam int PER_W     = 16;
  localparam int WIDE_W    = 38;   // frequency times the minimum period
  localparam int DIV_W     = CLK_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Timer limits
  localparam logic [PER_W-1:0] MAX_PRESCALER = 16'hFFFF;
  localparam int               PERIOD_SHIFT  = 16;     // log2 of the largest period plus one
  localparam int               MIN_PERIOD    = 100;

  // Register indexes of the configuration port
  typedef enum logic [1:0] {
    CFG_SLOW_BUS = 2'd0,
    CFG_FAST_BUS = 2'd1,
    CFG_DOUBLING = 2'd2
  } cfg_idx_t;

  // Request and result transactions
  typedef struct packed {
    logic               on_slow_bus;
    logic signed [31:0] wanted_frequency;
  } req_t;

  typedef struct packed {
    logic        failed;
    logic [15:0] prescale_setting;
    logic [15:0] reload_setting;
    logic [29:0] achieved_frequency;
  } rsp_t;

  // Microcode fields
  typedef enum logic [3:0] {
    OP_IDLE = 4'b0001,
    OP_TEST = 4'b0010,
    OP_DIV  = 4'b0100,
    OP_EMIT = 4'b1000
  } op_t;

  typedef enum logic [1:0] {
    COND_RANGE       = 2'd0,
    COND_PRESC_LIMIT = 2'd1,
    COND_PERIOD_ZERO = 2'd2
  } cond_t;

  typedef enum logic [1:0] {
    NUM_CLOCK_HI = 2'd0,
    NUM_CLOCK    = 2'd1,
    NUM_QUOT     = 2'd2
  } num_sel_t;

  typedef enum logic [1:0] {
    DEN_FREQ   = 2'd0,
    DEN_PRESC  = 2'd1,
    DEN_PERIOD = 2'd2
  } den_sel_t;

  typedef enum logic [1:0] {
    DST_PRESC    = 2'd0,
    DST_QUOT     = 2'd1,
    DST_PERIOD   = 2'd2,
    DST_ACHIEVED = 2'd3
  } dst_t;

  typedef logic [3:0] step_t;

  // Program steps
  localparam step_t STEP_IDLE      = 4'd0;
  localparam step_t STEP_RANGE     = 4'd1;
  localparam step_t STEP_DIV_PRESC = 4'd2;
  localparam step_t STEP_LIMIT     = 4'd3;
  localparam step_t STEP_DIV_CLK   = 4'd4;
  localparam step_t STEP_DIV_PER   = 4'd5;
  localparam step_t STEP_PER_ZERO  = 4'd6;
  localparam step_t STEP_DIV_ACH   = 4'd7;
  localparam step_t STEP_EMIT_OK   = 4'd8;
  localparam step_t STEP_EMIT_FAIL = 4'd9;

  typedef struct packed {
    op_t      op;
    cond_t    cond;
    num_sel_t num;
    den_sel_t den;
    dst_t     dst;
    logic     fail;
    step_t    target;
  } ctrl_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(input step_t step);
    ctrl_t w;
    w = '{op: OP_IDLE, cond: COND_RANGE, num: NUM_CLOCK, den: DEN_FREQ,
          dst: DST_QUOT, fail: 1'b0, target: STEP_IDLE};
    case (step)
      STEP_IDLE: begin
        w.op = OP_IDLE;
      end
      STEP_RANGE: begin
        w.op     = OP_TEST;
        w.cond   = COND_RANGE;
        w.target = STEP_EMIT_FAIL;
      end
      STEP_DIV_PRESC: begin
        w.op  = OP_DIV;
        w.num = NUM_CLOCK_HI;
        w.den = DEN_FREQ;
        w.dst = DST_PRESC;
      end
      STEP_LIMIT: begin
        w.op     = OP_TEST;
        w.cond   = COND_PRESC_LIMIT;
        w.target = STEP_EMIT_FAIL;
      end
      STEP_DIV_CLK: begin
        w.op  = OP_DIV;
        w.num = NUM_CLOCK;
        w.den = DEN_PRESC;
        w.dst = DST_QUOT;
      end
      STEP_DIV_PER: begin
        w.op  = OP_DIV;
        w.num = NUM_QUOT;
        w.den = DEN_FREQ;
        w.dst = DST_PERIOD;
      end
      STEP_PER_ZERO: begin
        w.op     = OP_TEST;
        w.cond   = COND_PERIOD_ZERO;
        w.target = STEP_EMIT_FAIL;
      end
      STEP_DIV_ACH: begin
        w.op  = OP_DIV;
        w.num = NUM_QUOT;
        w.den = DEN_PERIOD;
        w.dst = DST_ACHIEVED;
      end
      STEP_EMIT_OK: begin
        w.op     = OP_EMIT;
        w.fail   = 1'b0;
        w.target = STEP_IDLE;
      end
      STEP_EMIT_FAIL: begin
        w.op     = OP_EMIT;
        w.fail   = 1'b1;
        w.target = STEP_IDLE;
      end
      default: begin
        w.op = OP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/pwm_prescaler_period_search.sv -----
// PWM prescaler and period search: top level with microcode sequencer and shared divider.
// Depends on pwmpps_pkg and pwm_prescaler_period_search_macros.svh.
//
// One request at a time. A request is taken only while the sequencer sits at its idle step
// and the result comes out of a register, so a new request may be taken while the last result
// still waits. A request whose frequency is out of range goes from the range test straight to
// the failing emit step; any other runs four divisions on the one shared restoring divider at
// one quotient bit per cycle (a load and then 30 quotient bits each), plus the test and emit
// steps. The emit step waits while an earlier result is still held under stall. The timer
// clock is the selected bus clock times 2, or times 4 with the doubling register set;
// registers may be written at any time the block is idle and are always ready.
`include "pwm_prescaler_period_search_macros.svh"

module pwm_prescaler_period_search (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [27:0]        cfg_data,
  // request channel
  input  logic               req_valid,
  output logic               req_stall,
  input  pwmpps_pkg::req_t   req,
  // result channel
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output pwmpps_pkg::rsp_t   rsp
);

  import pwmpps_pkg::*;

  // Configuration registers
  logic [BUS_W-1:0]     slow_bus_clock_hz;
  logic [BUS_W-1:0]     fast_bus_clock_hz;
  logic                 timer_clock_doubling;

  // Sequencer and divider control
  step_t                step;
  ctrl_t                ctrl;
  logic                 div_busy;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Datapath registers
  logic [CLK_W-1:0]     clock_r;
  logic [FREQ_W-1:0]    freq_r;
  logic                 range_bad;
  logic [PER_W-1:0]     presc;
  logic [CLK_W-1:0]     quot;
  logic [PER_W-1:0]     period;
  logic [CLK_W-1:0]     achieved;
  logic [DIV_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_q;

  // Combinational
  logic                 accept;
  logic [BUS_W-1:0]     req_bus;
  logic [CLK_W-1:0]     req_clock;
  logic [WIDE_W-1:0]    freq_scaled;
  logic                 req_bad;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_den;
  logic [DIV_W:0]       div_shift;
  logic [DIV_W:0]       div_diff;
  logic                 div_fits;
  logic [DIV_W-1:0]     rem_next;
  logic [DIV_W-1:0]     q_next;
  logic                 div_load;
  logic                 div_last;
  logic                 cond_hit;
  logic                 emit;

  // Decode the current step
  always_comb begin
    ctrl = ucode(step);
  end

  assign cfg_ready = 1'b1;
  assign req_stall = (ctrl.op != OP_IDLE);
  assign accept    = req_valid && !req_stall;

  // Timer clock and frequency range test on the incoming request
  always_comb begin
    req_bus     = req.on_slow_bus ? slow_bus_clock_hz : fast_bus_clock_hz;
    req_clock   = timer_clock_doubling ? {req_bus, 2'b00} : {1'b0, req_bus, 1'b0};
    freq_scaled = WIDE_W'(req.wanted_frequency[30:0]) * WIDE_W'(MIN_PERIOD);
    req_bad     = req.wanted_frequency[31] || (req.wanted_frequency == '0) ||
                  (freq_scaled > WIDE_W'(req_clock));
  end

  // Divider operand selection
  always_comb begin
    case (ctrl.num)
      NUM_CLOCK_HI: div_num = DIV_W'(clock_r >> PERIOD_SHIFT);
      NUM_CLOCK:    div_num = clock_r;
      NUM_QUOT:     div_num = quot;
      default:      div_num = clock_r;
    endcase
    case (ctrl.den)
      DEN_FREQ:   div_den = DIV_W'(freq_r);
      DEN_PRESC:  div_den = DIV_W'(presc);
      DEN_PERIOD: div_den = DIV_W'(period);
      default:    div_den = DIV_W'(freq_r);
    endcase
  end

  // One restoring division step
  always_comb begin
    div_shift = {div_rem, div_q[DIV_W-1]};
    div_diff  = div_shift - {1'b0, div_den};
    div_fits  = !div_diff[DIV_W];
    rem_next  = div_fits ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
    q_next    = {div_q[DIV_W-2:0], div_fits};
  end

  // Jump conditions
  always_comb begin
    case (ctrl.cond)
      COND_RANGE:       cond_hit = range_bad;
      COND_PRESC_LIMIT: cond_hit = (presc >= MAX_PRESCALER);
      COND_PERIOD_ZERO: cond_hit = (period == '0);
      default:          cond_hit = 1'b0;
    endcase
  end

  assign div_load = (ctrl.op == OP_DIV) && !div_busy;
  assign div_last = (ctrl.op == OP_DIV) && div_busy && (div_cnt == DIV_CNT_W'(1));
  assign emit     = (ctrl.op == OP_EMIT) && (!rsp_valid || !rsp_stall);

  // Control state, registers and step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slow_bus_clock_hz    <= 28'd42000000;
      fast_bus_clock_hz    <= 28'd84000000;
      timer_clock_doubling <= 1'b0;
      step                 <= STEP_IDLE;
      div_busy             <= 1'b0;
      div_cnt              <= '0;
      rsp_valid            <= 1'b0;
    end else begin
      // take register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SLOW_BUS: slow_bus_clock_hz    <= cfg_data;
          CFG_FAST_BUS: fast_bus_clock_hz    <= cfg_data;
          CFG_DOUBLING: timer_clock_doubling <= cfg_data[0];
          default: ;
        endcase
      end

      // drop the result once taken, unless a new one replaces it
      if (rsp_valid && !rsp_stall && !emit) begin
        rsp_valid <= 1'b0;
      end

      // advance the program
      case (ctrl.op)
        OP_IDLE: begin
          if (accept) begin
            step <= step_t'(step + 1'b1);
          end
        end
        OP_TEST: begin
          step <= cond_hit ? ctrl.target : step_t'(step + 1'b1);
        end
        OP_DIV: begin
          if (div_load) begin
            div_busy <= 1'b1;
            div_cnt  <= DIV_CNT_W'(DIV_W);
          end else begin
            div_cnt <= div_cnt - 1'b1;
            if (div_last) begin
              div_busy <= 1'b0;
              step     <= step_t'(step + 1'b1);
            end
          end
        end
        OP_EMIT: begin
          if (emit) begin
            rsp_valid <= 1'b1;
            step      <= ctrl.target;
          end
        end
        default: step <= STEP_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      clock_r   <= req_clock;
      freq_r    <= req.wanted_frequency[FREQ_W-1:0];
      range_bad <= req_bad;
    end

    if (div_load) begin
      div_rem <= '0;
      div_q   <= div_num;
    end else if ((ctrl.op == OP_DIV) && div_busy) begin
      div_rem <= rem_next;
      div_q   <= q_next;
    end

    // write back the quotient (plus one for the prescaler) on the last bit
    if (div_last) begin
      case (ctrl.dst)
        DST_PRESC:    presc    <= PER_W'(q_next + 1'b1);
        DST_QUOT:     quot     <= q_next;
        DST_PERIOD:   period   <= PER_W'(q_next);
        DST_ACHIEVED: achieved <= q_next;
        default: ;
      endcase
    end

    // hold the result until taken
    if (emit) begin
      if (ctrl.fail) begin
        rsp <= '{failed: 1'b1, default: '0};
      end else begin
        rsp <= '{failed:             1'b0,
                 prescale_setting:   presc - 1'b1,
                 reload_setting:     period - 1'b1,
                 achieved_frequency: achieved};
      end
    end
  end

  // Checks
  `PPS_ASSERT_IMPLY(a_div_in_step, div_busy, ctrl.op == OP_DIV, "divider running outside a division step")
  `PPS_ASSERT_NEXT(a_accept_starts, req_valid && !req_stall, step == STEP_RANGE, "accepted request did not start the program")
  `PPS_ASSERT_IMPLY(a_div_nonzero, div_load, div_den != '0, "division started with a zero divisor")
  `PPS_ASSERT_IMPLY(a_fail_zero, rsp_valid && rsp.failed, (rsp.prescale_setting == '0) && (rsp.reload_setting == '0) && (rsp.achieved_frequency == '0), "failed result carries non-zero settings")

endmodule
